FILE: design/cmbs_pkg.sv
package cmbs_pkg;

    localparam int MAX_FACE_SIZE_DEF    = 64;
    localparam int WEIGHT_FRAC_BITS_DEF = 8;

    localparam int COLOR_W   = 16;
    localparam int DIR_W     = 16;
    localparam int ABS_W     = DIR_W + 1;
    localparam int FACE_W    = 3;
    localparam int XY_W      = 6;
    localparam int CFG_W     = 7;
    localparam int NUM_FACES = 6;

    localparam logic [CFG_W-1:0] FACE_SIZE_RESET = 7'd64;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    // [2] red, [1] green, [0] blue
    typedef logic [2:0][COLOR_W-1:0] t_rgb;

    typedef struct packed {
        logic                      opcode;
        logic [FACE_W-1:0]         face_index;
        logic [XY_W-1:0]           texel_x;
        logic [XY_W-1:0]           texel_y;
        logic [COLOR_W-1:0]        write_red;
        logic [COLOR_W-1:0]        write_green;
        logic [COLOR_W-1:0]        write_blue;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
    } t_item;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [FACE_W-1:0]  hit_face;
        logic               zero_direction;
    } t_result;

    typedef struct packed {
        logic              is_sample;
        logic [FACE_W-1:0] wr_face;
        logic [XY_W-1:0]   wr_x;
        logic [XY_W-1:0]   wr_y;
        t_rgb              wr_rgb;
        logic [FACE_W-1:0] hit_face;
        logic              zero_dir;
        logic              black;
    } t_side;

endpackage

FILE: design/cmbs_face_map.sv
module cmbs_face_map
    import cmbs_pkg::*;
#(
    parameter int CW = 6,
    parameter int W  = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  t_item                     i_item,
    input  logic [CW-1:0]             i_size_m1,
    input  logic                      i_size_zero,
    output logic                      o_vld,
    output t_side                     o_side,
    output logic [ABS_W+CW+W-1:0]     o_num_u,
    output logic [ABS_W+CW+W-1:0]     o_num_v,
    output logic [ABS_W-1:0]          o_den
);

    localparam int PROD_W = ABS_W + CW;
    localparam int NUM_W  = ABS_W + CW + W;

    logic signed [ABS_W-1:0] dx, dy, dz, ax, ay, az, sc, tc, ma;
    logic [FACE_W-1:0]       face;
    logic                    zero;
    logic [ABS_W-1:0]        n_snum, n_tnum;
    t_side                   n_side;

    logic                    r1_vld, r2_vld;
    t_side                   r1_side, r2_side;
    logic [ABS_W-1:0]        r1_snum, r1_tnum, r1_ma;
    logic [ABS_W+CW+W-1:0]   r2_num_u, r2_num_v;
    logic [ABS_W-1:0]        r2_den;

    always_comb begin
        dx = ABS_W'(i_item.dir_x);
        dy = ABS_W'(i_item.dir_y);
        dz = ABS_W'(i_item.dir_z);
        ax = dx[ABS_W-1] ? -dx : dx;
        ay = dy[ABS_W-1] ? -dy : dy;
        az = dz[ABS_W-1] ? -dz : dz;
        zero = (dx == '0) && (dy == '0) && (dz == '0);
        if (ax >= ay && ax >= az) begin
            face = (dx > 0) ? FACE_POS_X : FACE_NEG_X;
            ma   = ax;
            sc   = (dx > 0) ? -dz : dz;
            tc   = -dy;
        end else if (ay >= az) begin
            face = (dy > 0) ? FACE_POS_Y : FACE_NEG_Y;
            ma   = ay;
            sc   = dx;
            tc   = (dy > 0) ? dz : -dz;
        end else begin
            face = (dz > 0) ? FACE_POS_Z : FACE_NEG_Z;
            ma   = az;
            sc   = (dz > 0) ? dx : -dx;
            tc   = -dy;
        end
        if (zero) begin
            face = FACE_POS_X;
        end
        // sc + ma lies in 0..2^16, exact modulo 2^17
        n_snum = sc + ma;
        n_tnum = tc + ma;

        n_side.is_sample = (i_item.opcode == OP_SAMPLE);
        n_side.wr_face   = i_item.face_index;
        n_side.wr_x      = i_item.texel_x;
        n_side.wr_y      = i_item.texel_y;
        n_side.wr_rgb    = {i_item.write_red, i_item.write_green, i_item.write_blue};
        n_side.hit_face  = face;
        n_side.zero_dir  = zero;
        n_side.black     = zero || i_size_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
        end
    end

    // num * 2^W / (2 * ma) taken as num * 2^(W-1) / ma; 2 * ma needs one bit more
    always_ff @(posedge i_clk) begin
        r1_side  <= n_side;
        r1_snum  <= n_snum;
        r1_tnum  <= n_tnum;
        r1_ma    <= ma;
        r2_side  <= r1_side;
        r2_num_u <= NUM_W'({PROD_W'(r1_snum) * PROD_W'(i_size_m1), (W - 1)'(0)});
        r2_num_v <= NUM_W'({PROD_W'(r1_tnum) * PROD_W'(i_size_m1), (W - 1)'(0)});
        r2_den   <= r1_ma;
    end

    assign o_vld   = r2_vld;
    assign o_side  = r2_side;
    assign o_num_u = r2_num_u;
    assign o_num_v = r2_num_v;
    assign o_den   = r2_den;

endmodule

FILE: design/cmbs_divider.sv
module cmbs_divider
    import cmbs_pkg::*;
#(
    parameter int DEN_W = ABS_W,
    parameter int QW    = 14,
    parameter int NUM_W = DEN_W + QW
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QW-1:0]    o_quo
);

    // one quotient bit per stage, MSB first; caller guarantees num < den * 2^QW
    logic [NUM_W-1:0] r_rem [QW];
    logic [DEN_W-1:0] r_den [QW];
    logic [QW-1:0]    r_quo [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QW-1:0]    quo_in;
        logic [NUM_W-1:0] sub;
        logic             take;

        if (g == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
        end

        assign sub  = NUM_W'(den_in) << (QW - 1 - g);
        assign take = (rem_in >= sub);

        always_ff @(posedge i_clk) begin
            r_rem[g] <= take ? (rem_in - sub) : rem_in;
            r_den[g] <= den_in;
            r_quo[g] <= quo_in | (take ? (QW'(1) << (QW - 1 - g)) : '0);
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

FILE: design/cmbs_texel_store.sv
module cmbs_texel_store
    import cmbs_pkg::*;
#(
    parameter int MAX_FACE_SIZE = MAX_FACE_SIZE_DEF,
    parameter int CW            = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  t_side         i_side,
    input  logic [CW-1:0] i_x0,
    input  logic [CW-1:0] i_x1,
    input  logic [CW-1:0] i_y0,
    input  logic [CW-1:0] i_y1,
    output t_rgb          o_c00,
    output t_rgb          o_c10,
    output t_rgb          o_c01,
    output t_rgb          o_c11
);

    // four banks by (row parity, column parity): one read port and one write port each
    localparam int HM         = (MAX_FACE_SIZE + 1) / 2;
    localparam int BANK_DEPTH = NUM_FACES * HM * HM;
    localparam int BAW        = $clog2(BANK_DEPTH);

    typedef struct packed {
        logic x0;
        logic x1;
        logic y0;
        logic y1;
    } t_par;

    logic [CW-1:0]  wx, wy;
    logic           w_ok;
    logic [1:0]     wbank;
    logic [BAW-1:0] n_waddr;
    logic [BAW-1:0] n_raddr [4];

    logic           r_we    [4];
    logic [BAW-1:0] r_raddr [4];
    logic [BAW-1:0] r_waddr;
    t_rgb           r_wdata;
    t_par           r_par, r_par2;
    t_rgb           r_rd    [4];

    always_comb begin
        wx      = CW'(i_side.wr_x);
        wy      = CW'(i_side.wr_y);
        w_ok    = i_vld && !i_side.is_sample && (32'(i_side.wr_face) < NUM_FACES)
                  && (32'(i_side.wr_x) < MAX_FACE_SIZE) && (32'(i_side.wr_y) < MAX_FACE_SIZE);
        wbank   = {wy[0], wx[0]};
        n_waddr = BAW'(i_side.wr_face) * BAW'(HM * HM) + BAW'(wy >> 1) * BAW'(HM)
                  + BAW'(wx >> 1);
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [CW-1:0] xs, ys;
        t_rgb          mem [BANK_DEPTH];

        assign xs = (i_x0[0] == 1'(b % 2)) ? i_x0 : i_x1;
        assign ys = (i_y0[0] == 1'(b / 2)) ? i_y0 : i_y1;
        assign n_raddr[b] = BAW'(i_side.hit_face) * BAW'(HM * HM) + BAW'(ys >> 1) * BAW'(HM)
                            + BAW'(xs >> 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_we[b] <= 1'b0;
            end else begin
                r_we[b] <= w_ok && (wbank == 2'(b));
            end
        end

        always_ff @(posedge i_clk) begin
            r_raddr[b] <= n_raddr[b];
            if (r_we[b]) begin
                mem[r_waddr] <= r_wdata;
            end
            r_rd[b] <= mem[r_raddr[b]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
        r_wdata <= i_side.wr_rgb;
        r_par   <= '{x0: i_x0[0], x1: i_x1[0], y0: i_y0[0], y1: i_y1[0]};
        r_par2  <= r_par;
    end

    assign o_c00 = r_rd[{r_par2.y0, r_par2.x0}];
    assign o_c10 = r_rd[{r_par2.y0, r_par2.x1}];
    assign o_c01 = r_rd[{r_par2.y1, r_par2.x0}];
    assign o_c11 = r_rd[{r_par2.y1, r_par2.x1}];

endmodule

FILE: design/cmbs_blend.sv
module cmbs_blend
    import cmbs_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  t_rgb         i_c00,
    input  t_rgb         i_c10,
    input  t_rgb         i_c01,
    input  t_rgb         i_c11,
    input  logic [W-1:0] i_tx,
    input  logic [W-1:0] i_ty,
    output t_rgb         o_rgb
);

    localparam int C0_W = COLOR_W + W;
    localparam int V_W  = COLOR_W + 2 * W;

    logic [W:0]        wx_inv, wy_inv;
    logic [C0_W-1:0]   r_c0 [3];
    logic [C0_W-1:0]   r_c1 [3];
    logic [W-1:0]      r_ty;
    t_rgb              r_out;

    assign wx_inv = ((W + 1)'(1) << W) - (W + 1)'(i_tx);
    assign wy_inv = ((W + 1)'(1) << W) - (W + 1)'(r_ty);

    always_ff @(posedge i_clk) begin
        r_ty <= i_ty;
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic [V_W-1:0] v;

        assign v = V_W'(r_c0[ch]) * V_W'(wy_inv) + V_W'(r_c1[ch]) * V_W'(r_ty)
                   + (V_W'(1) << (2 * W - 1));

        always_ff @(posedge i_clk) begin
            r_c0[ch]  <= C0_W'(i_c00[ch]) * C0_W'(wx_inv) + C0_W'(i_c10[ch]) * C0_W'(i_tx);
            r_c1[ch]  <= C0_W'(i_c01[ch]) * C0_W'(wx_inv) + C0_W'(i_c11[ch]) * C0_W'(i_tx);
            r_out[ch] <= v[V_W-1:2*W];
        end
    end

    assign o_rgb = r_out;

endmodule

FILE: design/cube_map_bilinear_sampler.sv
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+--------------------------------------
// item in  | start, busy, i_item            | taken at an edge with start & !busy
// result   | o_result_valid, o_result       | one-cycle strobe, taken at its edge
// config   | i_cfg_wr_en, i_cfg_wr_data     | edge length written when i_cfg_wr_en
//
// One item enters every cycle; busy is never raised.
// A sample's result strobes after the face map, dividers, store and blend; the
// one-bit-per-stage coordinate dividers give QW = clog2(MAX_FACE_SIZE) +
// WEIGHT_FRAC_BITS (14 at defaults) bits. Writes land at the texel read stage.
// Reset clears valids and the edge length only; texel banks hold no reset state.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module cube_map_bilinear_sampler
    import cmbs_pkg::*;
#(
    parameter int MAX_FACE_SIZE    = MAX_FACE_SIZE_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    output logic             o_result_valid,
    output t_result          o_result
);

    localparam int W     = WEIGHT_FRAC_BITS;
    localparam int CW    = $clog2(MAX_FACE_SIZE);
    localparam int SW    = $clog2(MAX_FACE_SIZE + 1);
    localparam int QW    = CW + W;
    localparam int NUM_W = ABS_W + CW + W;
    localparam int TOT   = QW + 5;
    localparam int CMP_W = (SW > CFG_W) ? SW : CFG_W;

    logic [CFG_W-1:0] r_edge_len;
    logic [CMP_W-1:0] size_ext;
    logic [SW-1:0]    size_eff;
    logic [CW-1:0]    size_m1;
    logic             size_zero;

    logic             fm_vld;
    t_side            fm_side;
    logic [NUM_W-1:0] fm_num_u, fm_num_v;
    logic [ABS_W-1:0] fm_den;
    logic [QW-1:0]    quo_u, quo_v;

    logic             r_vld_d  [TOT];
    t_side            r_side_d [TOT];

    logic [CW-1:0]    n_x0, n_x1, n_y0, n_y1;
    logic [W-1:0]     n_tx, n_ty;
    logic [SW-1:0]    x0p, y0p;
    logic             drop;
    logic [CW-1:0]    r_x0, r_x1, r_y0, r_y1;
    logic [W-1:0]     r_tx, r_ty;
    logic [W-1:0]     r_tx_d [2];
    logic [W-1:0]     r_ty_d [2];

    t_rgb             c00, c10, c01, c11, blend_rgb;
    t_side            side_end;
    logic             r_res_vld;
    t_result          r_res;
    t_result          n_res;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_len <= FACE_SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_edge_len <= i_cfg_wr_data;
        end
    end

    always_comb begin
        size_ext  = CMP_W'(r_edge_len);
        size_eff  = (size_ext > CMP_W'(MAX_FACE_SIZE)) ? SW'(MAX_FACE_SIZE) : SW'(size_ext);
        size_m1   = CW'(size_eff - 1'b1);
        size_zero = (r_edge_len == '0);
    end

    cmbs_face_map #(.CW(CW), .W(W)) u_face_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (start && !busy),
        .i_item      (i_item),
        .i_size_m1   (size_m1),
        .i_size_zero (size_zero),
        .o_vld       (fm_vld),
        .o_side      (fm_side),
        .o_num_u     (fm_num_u),
        .o_num_v     (fm_num_v),
        .o_den       (fm_den)
    );

    cmbs_divider #(.DEN_W(ABS_W), .QW(QW), .NUM_W(NUM_W)) u_div_u (
        .i_clk (i_clk),
        .i_num (fm_num_u),
        .i_den (fm_den),
        .o_quo (quo_u)
    );

    cmbs_divider #(.DEN_W(ABS_W), .QW(QW), .NUM_W(NUM_W)) u_div_v (
        .i_clk (i_clk),
        .i_num (fm_num_v),
        .i_den (fm_den),
        .o_quo (quo_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TOT; j++) begin
                r_vld_d[j] <= 1'b0;
            end
        end else begin
            r_vld_d[0] <= fm_vld;
            for (int j = 1; j < TOT; j++) begin
                r_vld_d[j] <= r_vld_d[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side_d[0] <= fm_side;
        for (int j = 1; j < TOT; j++) begin
            r_side_d[j] <= r_side_d[j-1];
        end
    end

    // texel indices and fractions; black or write items read texel 0
    always_comb begin
        drop = r_side_d[QW-1].black || !r_side_d[QW-1].is_sample;
        n_x0 = drop ? '0 : quo_u[QW-1:W];
        n_y0 = drop ? '0 : quo_v[QW-1:W];
        n_tx = drop ? '0 : quo_u[W-1:0];
        n_ty = drop ? '0 : quo_v[W-1:0];
        x0p  = SW'(n_x0) + 1'b1;
        y0p  = SW'(n_y0) + 1'b1;
        n_x1 = drop ? '0 : ((x0p < size_eff) ? CW'(x0p) : size_m1);
        n_y1 = drop ? '0 : ((y0p < size_eff) ? CW'(y0p) : size_m1);
    end

    always_ff @(posedge i_clk) begin
        r_x0      <= n_x0;
        r_x1      <= n_x1;
        r_y0      <= n_y0;
        r_y1      <= n_y1;
        r_tx      <= n_tx;
        r_ty      <= n_ty;
        r_tx_d[0] <= r_tx;
        r_tx_d[1] <= r_tx_d[0];
        r_ty_d[0] <= r_ty;
        r_ty_d[1] <= r_ty_d[0];
    end

    cmbs_texel_store #(.MAX_FACE_SIZE(MAX_FACE_SIZE), .CW(CW)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld_d[QW]),
        .i_side  (r_side_d[QW]),
        .i_x0    (r_x0),
        .i_x1    (r_x1),
        .i_y0    (r_y0),
        .i_y1    (r_y1),
        .o_c00   (c00),
        .o_c10   (c10),
        .o_c01   (c01),
        .o_c11   (c11)
    );

    cmbs_blend #(.W(W)) u_blend (
        .i_clk (i_clk),
        .i_c00 (c00),
        .i_c10 (c10),
        .i_c01 (c01),
        .i_c11 (c11),
        .i_tx  (r_tx_d[1]),
        .i_ty  (r_ty_d[1]),
        .o_rgb (blend_rgb)
    );

    always_comb begin
        side_end             = r_side_d[TOT-1];
        n_res.out_red        = side_end.black ? '0 : blend_rgb[2];
        n_res.out_green      = side_end.black ? '0 : blend_rgb[1];
        n_res.out_blue       = side_end.black ? '0 : blend_rgb[0];
        n_res.hit_face       = side_end.hit_face;
        n_res.zero_direction = side_end.zero_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_vld_d[TOT-1] && side_end.is_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    a_zero_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.zero_direction |->
            o_result.out_red == '0 && o_result.out_green == '0 &&
            o_result.out_blue == '0 && o_result.hit_face == FACE_POS_X)
        else $error("zero direction result not black on face 0");

    a_sample_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.opcode == OP_SAMPLE |-> ##(QW + 8) o_result_valid)
        else $error("sample item gave no result at expected latency");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.opcode == OP_WRITE |-> ##(QW + 8) !o_result_valid)
        else $error("write item produced a result");

endmodule

FILE: tb/sv/tb_cube_map_bilinear_sampler.sv
module tb_cube_map_bilinear_sampler;
    import cmbs_pkg::*;

    localparam int STORE_DEPTH = NUM_FACES * MAX_FACE_SIZE_DEF * MAX_FACE_SIZE_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_W = $bits(t_item);
    localparam int FILL_EDGE = 8;
    localparam int ROUND_ITEMS = 85;
    localparam int MAX_TRIES = 4000;

    class texel_scoreboard;
        logic [3*COLOR_W-1:0] texels [STORE_DEPTH];
        int unsigned edge_len;
        t_result pending[$];
        int errors;

        function new();
            edge_len = FACE_SIZE_RESET;
            errors = 0;
        endfunction

        function void split_coord(int s, int ma, int unsigned sz,
                                  output int unsigned idx,
                                  output int unsigned frac);
            longint q;
            q = ((longint'(s + ma) * longint'(sz - 1)) << WEIGHT_FRAC_BITS_DEF)
                / (2 * longint'(ma));
            if (q > (longint'(sz - 1) << WEIGHT_FRAC_BITS_DEF))
                q = longint'(sz - 1) << WEIGHT_FRAC_BITS_DEF;
            idx = 32'(q >> WEIGHT_FRAC_BITS_DEF);
            frac = 32'(q & ((longint'(1) << WEIGHT_FRAC_BITS_DEF) - 1));
        endfunction

        function int unsigned addr(int unsigned face, int unsigned x, int unsigned y);
            return face * MAX_FACE_SIZE_DEF * MAX_FACE_SIZE_DEF + y * MAX_FACE_SIZE_DEF + x;
        endfunction

        // face and neighbours of a sample; returns 1 when the color is blended
        function bit locate(t_item it, output int unsigned face,
                            output int unsigned x0, output int unsigned x1,
                            output int unsigned y0, output int unsigned y1,
                            output int unsigned tx, output int unsigned ty);
            int dx, dy, dz, ax, ay, az, ma, sc, tc;
            int unsigned sz;
            face = 0;
            x0 = 0;
            x1 = 0;
            y0 = 0;
            y1 = 0;
            tx = 0;
            ty = 0;
            dx = it.dir_x;
            dy = it.dir_y;
            dz = it.dir_z;
            if (dx == 0 && dy == 0 && dz == 0)
                return 0;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            az = dz < 0 ? -dz : dz;
            if (ax >= ay && ax >= az) begin
                face = dx > 0 ? FACE_POS_X : FACE_NEG_X;
                ma = ax;
                sc = dx > 0 ? -dz : dz;
                tc = -dy;
            end else if (ay >= az) begin
                face = dy > 0 ? FACE_POS_Y : FACE_NEG_Y;
                ma = ay;
                sc = dx;
                tc = dy > 0 ? dz : -dz;
            end else begin
                face = dz > 0 ? FACE_POS_Z : FACE_NEG_Z;
                ma = az;
                sc = dz > 0 ? dx : -dx;
                tc = -dy;
            end
            sz = edge_len;
            if (sz == 0)
                return 0;
            if (sz > MAX_FACE_SIZE_DEF)
                sz = MAX_FACE_SIZE_DEF;
            split_coord(sc, ma, sz, x0, tx);
            split_coord(tc, ma, sz, y0, ty);
            x1 = x0 + 1 < sz ? x0 + 1 : sz - 1;
            y1 = y0 + 1 < sz ? y0 + 1 : sz - 1;
            return 1;
        endfunction

        function bit reads_written(t_item it);
            int unsigned face, x0, x1, y0, y1, tx, ty;
            if (it.opcode == OP_WRITE)
                return 1;
            if (!locate(it, face, x0, x1, y0, y1, tx, ty))
                return 1;
            return !$isunknown(texels[addr(face, x0, y0)]) &&
                   !$isunknown(texels[addr(face, x1, y0)]) &&
                   !$isunknown(texels[addr(face, x0, y1)]) &&
                   !$isunknown(texels[addr(face, x1, y1)]);
        endfunction

        function void note_item(t_item it);
            t_result r;
            bit live;
            int unsigned face, x0, x1, y0, y1, tx, ty;
            longint one, c00, c10, c01, c11, c0, c1, v;
            if (it.opcode == OP_WRITE) begin
                if (it.face_index < NUM_FACES)
                    texels[addr(it.face_index, it.texel_x, it.texel_y)] =
                        {it.write_red, it.write_green, it.write_blue};
                return;
            end
            r = '0;
            r.zero_direction = (it.dir_x == 0 && it.dir_y == 0 && it.dir_z == 0);
            live = locate(it, face, x0, x1, y0, y1, tx, ty);
            r.hit_face = FACE_W'(face);
            if (live) begin
                one = longint'(1) << WEIGHT_FRAC_BITS_DEF;
                for (int c = 0; c < 3; c++) begin
                    c00 = texels[addr(face, x0, y0)][c*COLOR_W +: COLOR_W];
                    c10 = texels[addr(face, x1, y0)][c*COLOR_W +: COLOR_W];
                    c01 = texels[addr(face, x0, y1)][c*COLOR_W +: COLOR_W];
                    c11 = texels[addr(face, x1, y1)][c*COLOR_W +: COLOR_W];
                    c0 = c00 * (one - tx) + c10 * tx;
                    c1 = c01 * (one - tx) + c11 * tx;
                    v = c0 * (one - ty) + c1 * ty;
                    v = (v + (longint'(1) << (2*WEIGHT_FRAC_BITS_DEF - 1)))
                        >> (2*WEIGHT_FRAC_BITS_DEF);
                    case (c)
                        0: r.out_blue = v[15:0];
                        1: r.out_green = v[15:0];
                        default: r.out_red = v[15:0];
                    endcase
                end
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $error("result with no sample outstanding: %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.out_red !== exp.out_red) begin
                $error("out_red exp %h got %h", exp.out_red, got.out_red);
                errors++;
            end
            if (got.out_green !== exp.out_green) begin
                $error("out_green exp %h got %h", exp.out_green, got.out_green);
                errors++;
            end
            if (got.out_blue !== exp.out_blue) begin
                $error("out_blue exp %h got %h", exp.out_blue, got.out_blue);
                errors++;
            end
            if (got.hit_face !== exp.hit_face) begin
                $error("hit_face exp %0d got %0d", exp.hit_face, got.hit_face);
                errors++;
            end
            if (got.zero_direction !== exp.zero_direction) begin
                $error("zero_direction exp %b got %b", exp.zero_direction,
                       got.zero_direction);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy, i_cfg_wr_en, o_result_valid;
    logic [CFG_W-1:0] i_cfg_wr_data;
    t_item i_item;
    t_result o_result;

    texel_scoreboard sb;
    int idle_cycles;
    bit no_gaps;

    cube_map_bilinear_sampler DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_result_valid(o_result_valid),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_result);
        if ((start && !busy) || o_result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [DIR_W-1:0] pick_component();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
            default: return DIR_W'($urandom());
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        int k;
        it = ITEM_W'({$urandom(), $urandom(), $urandom(), $urandom()});
        it.opcode = $urandom_range(0, 9) < 4 ? OP_WRITE : OP_SAMPLE;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            it.dir_x = '0;
            it.dir_y = '0;
            it.dir_z = '0;
        end else if (k < 4) begin
            it.dir_x = pick_component();
            it.dir_y = pick_component();
            it.dir_z = pick_component();
        end else if (k < 6) begin
            // equal magnitudes exercise the axis tie-break
            it.dir_y = $urandom_range(0, 1) ? it.dir_x : -it.dir_x;
            if (k == 5)
                it.dir_z = $urandom_range(0, 1) ? it.dir_x : -it.dir_x;
        end
        return it;
    endfunction

    task automatic send(t_item it, bit gaps);
        int n;
        n = 0;
        if (gaps && !no_gaps) begin
            case ($urandom_range(0, 19))
                0: n = $urandom_range(10, 40);
                1, 2, 3, 4, 5: n = $urandom_range(1, 3);
                default: n = 0;
            endcase
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        sb.note_item(it);
    endtask

    // samples only read texels that have been written
    task automatic send_random();
        t_item it;
        int tries;
        it = random_item();
        tries = 0;
        if (it.opcode == OP_SAMPLE) begin
            while (!sb.reads_written(it) && tries < MAX_TRIES) begin
                it = random_item();
                it.opcode = OP_SAMPLE;
                tries++;
            end
            if (!sb.reads_written(it)) begin
                it.dir_x = '0;
                it.dir_y = '0;
                it.dir_z = '0;
            end
        end
        send(it, 1);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.edge_len = v;
    endtask

    function automatic t_item dir_item(int x, int y, int z);
        t_item it;
        it = ITEM_W'({$urandom(), $urandom(), $urandom(), $urandom()});
        it.opcode = OP_SAMPLE;
        it.dir_x = DIR_W'(x);
        it.dir_y = DIR_W'(y);
        it.dir_z = DIR_W'(z);
        return it;
    endfunction

    initial begin
        t_item it;
        logic [CFG_W-1:0] sizes [9];
        sb = new();
        sizes = '{7'd64, 7'd1, 7'd2, 7'd0, 7'd127, 7'd65, 7'd3, 7'd8, 7'd64};
        idle_cycles <= 0;
        no_gaps = 0;
        start <= 1'b0;
        i_item <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the low corner of every face; small edge lengths read only there
        for (int f = 0; f < NUM_FACES; f++)
            for (int y = 0; y < FILL_EDGE; y++)
                for (int x = 0; x < FILL_EDGE; x++) begin
                    it = random_item();
                    it.opcode = OP_WRITE;
                    it.face_index = FACE_W'(f);
                    it.texel_x = XY_W'(x);
                    it.texel_y = XY_W'(y);
                    send(it, 0);
                end

        settle();
        write_size(CFG_W'(FILL_EDGE));

        // directed: axis extremes, ties, zero vector, ignored faces, far corner
        send(dir_item(0, 0, 0), 1);
        send(dir_item(32767, 0, 0), 1);
        send(dir_item(-32768, 0, 0), 1);
        send(dir_item(0, 32767, 0), 1);
        send(dir_item(0, -32768, 0), 1);
        send(dir_item(0, 0, 32767), 1);
        send(dir_item(0, 0, -32768), 1);
        send(dir_item(32767, 32767, 32767), 1);
        send(dir_item(-32768, -32768, -32768), 1);
        send(dir_item(100, -100, 5), 1);
        send(dir_item(3, 200, -200), 1);
        send(dir_item(32767, -32768, 32767), 1);
        send(dir_item(1, 0, 0), 1);
        for (int f = 6; f < 8; f++) begin
            it = random_item();
            it.opcode = OP_WRITE;
            it.face_index = FACE_W'(f);
            send(it, 1);
        end
        it = random_item();
        it.opcode = OP_WRITE;
        it.face_index = FACE_NEG_Z;
        it.texel_x = XY_W'(FILL_EDGE - 1);
        it.texel_y = XY_W'(FILL_EDGE - 1);
        it.write_red = '1;
        it.write_green = '1;
        it.write_blue = '1;
        send(it, 1);
        send(dir_item(-32767, -32767, -32768), 1);
        send(dir_item(-32768, -32768, -32768), 1);
        send(dir_item(-32767, 32767, -32767), 1);

        foreach (sizes[p]) begin
            settle();
            write_size(sizes[p]);
            no_gaps = (p % 3 == 2);
            repeat (ROUND_ITEMS) send_random();
        end
        settle();

        if (sb.pending.size() != 0)
            sb.errors++;
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/cmbs_pkg.sv
design/cmbs_face_map.sv
design/cmbs_divider.sv
design/cmbs_texel_store.sv
design/cmbs_blend.sv
design/cube_map_bilinear_sampler.sv
tb/sv/tb_cube_map_bilinear_sampler.sv
